### hdl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pps_pkg.sv
package pps_pkg;

    // Fixed field widths of the channels
    localparam int SLOT_W  = 4;
    localparam int FIELD_W = 16;
    localparam int PRIO_W  = 8;
    localparam int CNT_W   = 5;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // One result beat
    typedef struct packed {
        logic               idle;
        logic [SLOT_W-1:0]  ran_slot;
        logic [FIELD_W-1:0] tick_time;
        logic               first_run;
        logic               finished;
        logic [FIELD_W-1:0] turnaround;
        logic [FIELD_W-1:0] waiting;
        logic               all_done;
    } rsp_t;

endpackage

### hdl/pps_cfg_if.sv
interface pps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pps_pkg::CNT_W-1:0]  process_count;

    modport source (output valid, output process_count, input ready);
    modport sink   (input valid, input process_count, output ready);
endinterface

### hdl/pps_req_if.sv
interface pps_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [pps_pkg::SLOT_W-1:0]         slot;
    logic [pps_pkg::FIELD_W-1:0]        arrival;
    logic [pps_pkg::FIELD_W-1:0]        burst;
    logic signed [pps_pkg::PRIO_W-1:0]  prio;

    modport source (output valid, output func, output slot, output arrival,
                    output burst, output prio, input ready);
    modport sink   (input valid, input func, input slot, input arrival,
                    input burst, input prio, output ready);
endinterface

### hdl/pps_rsp_if.sv
interface pps_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           idle;
    logic [pps_pkg::SLOT_W-1:0]     ran_slot;
    logic [pps_pkg::FIELD_W-1:0]    tick_time;
    logic                           first_run;
    logic                           finished;
    logic [pps_pkg::FIELD_W-1:0]    turnaround;
    logic [pps_pkg::FIELD_W-1:0]    waiting;
    logic                           all_done;

    modport source (output valid, output idle, output ran_slot, output tick_time,
                    output first_run, output finished, output turnaround,
                    output waiting, output all_done, input ready);
    modport sink   (input valid, input idle, input ran_slot, input tick_time,
                    input first_run, input finished, input turnaround,
                    input waiting, input all_done, output ready);
endinterface

### hdl/pps_pick.sv
// Shared compare unit: decides whether the scanned candidate beats the
// best slot found so far in this tick.
module pps_pick #(
    parameter int TIME_BITS = 16
) (
    input  logic                               cand_done,
    input  logic [TIME_BITS-1:0]               cand_arr,
    input  logic signed [pps_pkg::PRIO_W-1:0]  cand_prio,
    input  logic [TIME_BITS-1:0]               now,
    input  logic                               best_found,
    input  logic [TIME_BITS-1:0]               best_arr,
    input  logic signed [pps_pkg::PRIO_W-1:0]  best_prio,
    output logic                               take
);

    logic eligible;
    logic better;

    // arrived and not yet complete
    assign eligible = !cand_done && (cand_arr <= now);

    // higher priority wins; tie goes to earlier arrival; scan order keeps
    // the lower slot on a full tie
    assign better = (cand_prio > best_prio) ||
                    ((cand_prio == best_prio) && (cand_arr < best_arr));

    assign take = eligible && (!best_found || better);

endmodule

### hdl/pps_upd.sv
// Commit arithmetic for the slot that runs: remaining-time decrement,
// saturating time advance, turnaround and waiting on completion.
module pps_upd #(
    parameter int TIME_BITS = 16
) (
    input  logic [TIME_BITS-1:0] now,
    input  logic [TIME_BITS-1:0] remaining,
    input  logic [TIME_BITS-1:0] arrival,
    input  logic [TIME_BITS-1:0] burst,
    output logic [TIME_BITS-1:0] now_inc,
    output logic [TIME_BITS-1:0] rem_next,
    output logic                 fin,
    output logic [TIME_BITS-1:0] turn,
    output logic [TIME_BITS-1:0] wait_time
);

    // time saturates at all ones
    assign now_inc = (now != '1) ? now + TIME_BITS'(1) : now;

    // runs out this tick when one or zero units remain
    assign fin      = (remaining <= TIME_BITS'(1));
    assign rem_next = fin ? '0 : remaining - TIME_BITS'(1);

    // completion time equals the advanced time
    assign turn      = now_inc - arrival;
    assign wait_time = (turn > burst) ? turn - burst : '0;

endmodule

### hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. A load beat (func = 0) writes one process
// slot. A tick beat (func = 1) walks slots 0..N-1, where N is process_count
// clamped to SLOTS, through one slot-table read port and one shared compare
// unit, one slot per cycle; it then rereads the winning slot and commits.
// req.ready stays low until the tick is done; the commit also waits for the
// previous result to be taken. Each tick returns one result beat, loads
// return none.
// The slot table is undefined until loaded; only loaded slots may be counted.
module preemptive_priority_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pps_cfg_if.sink    cfg,
    pps_req_if.sink    req,
    pps_rsp_if.source  rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = pps_pkg::PRIO_W;
    localparam int FW = pps_pkg::FIELD_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_FETCH   = 3'd4;

    typedef struct packed {
        logic signed [PW-1:0]  prio;
        logic [TIME_BITS-1:0]  arrival;
        logic [TIME_BITS-1:0]  burst;
        logic [TIME_BITS-1:0]  remaining;
    } entry_t;

    // registers
    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           iss_reg, iss_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [SW-1:0]           pend_idx_reg, pend_idx_next;
    logic                    found_reg, found_next;
    logic [SW-1:0]           best_idx_reg, best_idx_next;
    logic signed [PW-1:0]    best_prio_reg, best_prio_next;
    logic [TIME_BITS-1:0]    best_arr_reg, best_arr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic [SLOTS-1:0]        started_reg, started_next;
    logic [SLOTS-1:0]        done_reg, done_next;
    logic [pps_pkg::CNT_W-1:0] pc_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    pps_pkg::rsp_t           out_reg, out_next;

    // slot table
    entry_t                  mem [SLOTS];
    entry_t                  rd_entry_reg;
    logic                    mem_we;
    logic [SW-1:0]           mem_waddr;
    entry_t                  mem_wdata;
    logic                    mem_re;
    logic [SW-1:0]           mem_raddr;

    // misc
    logic [CW-1:0]           n_eff;
    logic                    ld_ok;
    logic [SW-1:0]           ld_idx;
    logic [TIME_BITS-1:0]    ld_burst;
    logic                    take;
    logic                    commit;
    entry_t                  upd_entry;
    logic [TIME_BITS-1:0]    now_inc;
    logic [TIME_BITS-1:0]    rem_next;
    logic                    fin;
    logic [TIME_BITS-1:0]    turn;
    logic [TIME_BITS-1:0]    wait_time;

    // configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (cfg.valid)
        begin
            pc_reg <= cfg.process_count;
        end
    end

    // effective slot count
    always_comb
    begin
        if (int'(pc_reg) > SLOTS)
        begin
            n_eff = CW'(SLOTS);
        end
        else
        begin
            n_eff = CW'(pc_reg);
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign ld_ok     = (int'(req.slot) < SLOTS);
    assign ld_idx    = SW'(req.slot);
    assign ld_burst  = TIME_BITS'(req.burst);

    // slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_entry_reg <= mem[mem_raddr];
        end
    end

    // compare unit on the entry read in the previous cycle
    pps_pick #(
        .TIME_BITS (TIME_BITS)
    ) u_pick (
        .cand_done  (done_reg[pend_idx_reg]),
        .cand_arr   (rd_entry_reg.arrival),
        .cand_prio  (rd_entry_reg.prio),
        .now        (now_reg),
        .best_found (found_reg),
        .best_arr   (best_arr_reg),
        .best_prio  (best_prio_reg),
        .take       (take)
    );

    // commit arithmetic on the winner
    pps_upd #(
        .TIME_BITS (TIME_BITS)
    ) u_upd (
        .now       (now_reg),
        .remaining (rd_entry_reg.remaining),
        .arrival   (rd_entry_reg.arrival),
        .burst     (rd_entry_reg.burst),
        .now_inc   (now_inc),
        .rem_next  (rem_next),
        .fin       (fin),
        .turn      (turn),
        .wait_time (wait_time)
    );

    assign commit = (state_reg == ST_FETCH) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        upd_entry           = rd_entry_reg;
        upd_entry.remaining = rem_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_arr_next  = best_arr_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = ld_idx;
        mem_wdata      = upd_entry;
        mem_re         = 1'b0;
        mem_raddr      = iss_reg[SW-1:0];

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end

        // fold the candidate read last cycle into the running best
        if (pend_vld_reg)
        begin
            if (take)
            begin
                found_next     = 1'b1;
                best_idx_next  = pend_idx_reg;
                best_prio_next = rd_entry_reg.prio;
                best_arr_next  = rd_entry_reg.arrival;
            end
            if (!done_reg[pend_idx_reg] && (cnt_reg != 2'd2))
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == pps_pkg::FUNC_LOAD)
                    begin
                        if (ld_ok)
                        begin
                            mem_we                    = 1'b1;
                            mem_waddr                 = ld_idx;
                            mem_wdata.prio            = req.prio;
                            mem_wdata.arrival         = TIME_BITS'(req.arrival);
                            mem_wdata.burst           = ld_burst;
                            mem_wdata.remaining       = ld_burst;
                            started_next[ld_idx]      = 1'b0;
                            done_next[ld_idx]         = (ld_burst == '0);
                        end
                    end
                    else
                    begin
                        iss_next   = '0;
                        found_next = 1'b0;
                        cnt_next   = 2'd0;
                        if (n_eff == '0)
                        begin
                            state_next = ST_RESOLVE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                mem_re        = 1'b1;
                mem_raddr     = iss_reg[SW-1:0];
                pend_vld_next = 1'b1;
                pend_idx_next = iss_reg[SW-1:0];
                iss_next      = iss_reg + CW'(1);
                if (iss_reg == n_eff - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_RESOLVE;
            end

            ST_RESOLVE:
            begin
                mem_re     = 1'b1;
                mem_raddr  = best_idx_reg;
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                if (commit)
                begin
                    rsp_valid_next     = 1'b1;
                    now_next           = now_inc;
                    out_next           = '0;
                    out_next.tick_time = FW'(now_reg);
                    if (!found_reg)
                    begin
                        out_next.idle     = 1'b1;
                        out_next.all_done = (cnt_reg == 2'd0);
                    end
                    else
                    begin
                        out_next.ran_slot  = pps_pkg::SLOT_W'(best_idx_reg);
                        out_next.first_run = !started_reg[best_idx_reg];
                        started_next[best_idx_reg] = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = best_idx_reg;
                        mem_wdata = upd_entry;
                        if (fin)
                        begin
                            done_next[best_idx_reg] = 1'b1;
                            out_next.finished   = 1'b1;
                            out_next.turnaround = FW'(turn);
                            out_next.waiting    = FW'(wait_time);
                        end
                        out_next.all_done = (cnt_reg == 2'd0) ||
                                            ((cnt_reg == 2'd1) && fin);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= 2'd0;
            now_reg       <= '0;
            started_reg   <= '0;
            done_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            pend_vld_reg  <= pend_vld_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            started_reg   <= started_next;
            done_reg      <= done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_arr_reg  <= best_arr_next;
        out_reg       <= out_next;
    end

    // result channel
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.idle       = out_reg.idle;
    assign rsp.ran_slot   = out_reg.ran_slot;
    assign rsp.tick_time  = out_reg.tick_time;
    assign rsp.first_run  = out_reg.first_run;
    assign rsp.finished   = out_reg.finished;
    assign rsp.turnaround = out_reg.turnaround;
    assign rsp.waiting    = out_reg.waiting;
    assign rsp.all_done   = out_reg.all_done;

    // checks
`include "assert_macros.svh"

    `PPS_ASSERT_IMPLY(a_idle_clean, rsp.valid && rsp.idle, !rsp.finished && !rsp.first_run && rsp.ran_slot == '0, "idle beat carries slot data")
    `PPS_ASSERT_IMPLY(a_best_in_range, state_reg == ST_FETCH && found_reg, best_idx_reg < n_eff, "winner outside counted slots")
    `PPS_ASSERT_IMPLY(a_scan_bound, state_reg != ST_IDLE, iss_reg <= n_eff, "scan ran past the slot count")
    `PPS_ASSERT_NEXT(a_time_mono, 1'b1, now_reg >= $past(now_reg), "time counter went backward")

endmodule
